[rtl/core/wrc_pkg.sv]
`timescale 1ns / 1ps

package wrc_pkg;

  // Item kinds carried on the input channel.
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_ADD    = 2'd1;
  localparam logic [1:0] KIND_CHOOSE = 2'd2;

  // Result status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // Fixed field widths.
  localparam int unsigned KIND_BITS   = 2;
  localparam int unsigned STATUS_BITS = 2;
  localparam int unsigned DRAW_BITS   = 32;

  // The threshold multiplier takes the total in slices of this width.
  localparam int unsigned SLICE_BITS = 16;

  // Top-level control sequence.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_HOLD
  } state_t;

endpackage

[rtl/core/wrc_if.sv]
`timescale 1ns / 1ps

// Input channel: one item per handshake.
interface wrc_in_if #(
  parameter int unsigned ID_BITS     = 16,
  parameter int unsigned WEIGHT_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             kind;
  logic [ID_BITS-1:0]     option_id;
  logic [WEIGHT_BITS-1:0] option_weight;
  logic [31:0]            random_draw;

  modport source (output valid, kind, option_id, option_weight, random_draw, input ready);
  modport sink   (input valid, kind, option_id, option_weight, random_draw, output ready);
endinterface

// Result channel: one item per handshake.
interface wrc_out_if #(
  parameter int unsigned ID_BITS = 16
);
  logic               valid;
  logic               ready;
  logic [ID_BITS-1:0] chosen_id;
  logic [1:0]         status;

  modport source (output valid, chosen_id, status, input ready);
  modport sink   (input valid, chosen_id, status, output ready);
endinterface

[rtl/core/weighted_random_choice_core.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// in_ch     sink       valid / ready      kind, option_id, option_weight, random_draw
// out_ch    source     valid / ready      chosen_id, status
//
// Clear, add, an unused kind and a failed choose answer in the cycle after the item is taken.
// A choose passes through the threshold multiplier, then the token walks the cell row,
// the pick is captured and the output register is loaded. One item is in flight at a time.
// Reset (synchronous, active low) empties the table at once; a stalled result holds in
// the output register and blocks the next item, except a choose on a non-empty table,
// which is taken and then waits in S_HOLD until the output register is free.
module weighted_random_choice_core #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned WEIGHT_BITS = 16,
  parameter int unsigned ID_BITS     = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  wrc_in_if.sink     in_ch,
  wrc_out_if.source  out_ch
);
  import wrc_pkg::*;

  localparam int unsigned TOT_BITS = WEIGHT_BITS + $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_BITS = $clog2(TABLE_DEPTH + 1);

  state_t               state_r, state_nxt;
  logic [CNT_BITS-1:0]  count_r;
  logic [TOT_BITS-1:0]  total_r;
  logic [TOT_BITS-1:0]  total_sum;
  logic [ID_BITS-1:0]   res_id_r;

  logic                 out_valid_r;
  logic [ID_BITS-1:0]   out_id_r;
  logic [1:0]           out_status_r;
  logic                 load_out;
  logic [ID_BITS-1:0]   load_id;
  logic [1:0]           load_status;

  logic                 out_free;
  logic                 empty;
  logic                 full;
  logic                 immediate;
  logic                 accept;
  logic                 is_add;
  logic                 is_clear;
  logic                 start_scale;
  logic                 scale_done;
  logic [TOT_BITS-1:0]  threshold;

  logic [TOT_BITS-1:0]  cell_cum   [TABLE_DEPTH];
  logic [ID_BITS-1:0]   cell_id    [TABLE_DEPTH];
  logic                 cell_tvld  [TABLE_DEPTH];
  logic [TOT_BITS-1:0]  cell_tthr  [TABLE_DEPTH];
  logic [ID_BITS-1:0]   cell_tid   [TABLE_DEPTH];

  // Table status and acceptance.
  assign out_free  = !out_valid_r || out_ch.ready;
  assign empty     = (count_r == '0) || (total_r == '0);
  assign full      = (count_r == CNT_BITS'(TABLE_DEPTH));
  assign immediate = (in_ch.kind != KIND_CHOOSE) || empty;
  assign in_ch.ready = (state_r == S_IDLE) && (!immediate || out_free);
  assign accept    = in_ch.valid && in_ch.ready;
  assign is_add    = accept && (in_ch.kind == KIND_ADD) && !full;
  assign is_clear  = accept && (in_ch.kind == KIND_CLEAR);
  assign total_sum = total_r + TOT_BITS'(in_ch.option_weight);

  // Next state and result loading.
  always_comb begin
    state_nxt   = state_r;
    load_out    = 1'b0;
    load_id     = '0;
    load_status = STATUS_OK;
    start_scale = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (immediate) begin
            load_out = 1'b1;
            if (in_ch.kind == KIND_ADD && full) begin
              load_status = STATUS_FULL;
            end else if (in_ch.kind == KIND_CHOOSE) begin
              load_status = STATUS_EMPTY;
            end
          end else begin
            start_scale = 1'b1;
            state_nxt   = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (cell_tvld[TABLE_DEPTH-1]) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          load_out  = 1'b1;
          load_id   = res_id_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the search result as the token leaves the last cell.
  always_ff @(posedge clk) begin
    if (state_r == S_SEARCH && cell_tvld[TABLE_DEPTH-1]) begin
      res_id_r <= cell_tid[TABLE_DEPTH-1];
    end
  end

  // Entry count and running total.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      total_r <= '0;
    end else if (is_clear) begin
      count_r <= '0;
      total_r <= '0;
    end else if (is_add) begin
      count_r <= count_r + 1'b1;
      total_r <= total_sum;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_id_r     <= load_id;
      out_status_r <= load_status;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.chosen_id = out_id_r;
  assign out_ch.status    = out_status_r;

  // Threshold multiplier.
  wrc_scaler #(
    .TOT_BITS (TOT_BITS)
  ) u_scaler (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start_scale),
    .draw      (in_ch.random_draw),
    .total     (total_r),
    .done      (scale_done),
    .threshold (threshold)
  );

  // Row of entry cells; the first cell takes the new entry and the token.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      wrc_cell #(
        .IDX      (i),
        .TOT_BITS (TOT_BITS),
        .ID_BITS  (ID_BITS),
        .CNT_BITS (CNT_BITS)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .shift_en    (is_add),
        .cum_in      (total_sum),
        .id_in       (in_ch.option_id),
        .cum_out     (cell_cum[i]),
        .id_out      (cell_id[i]),
        .count       (count_r),
        .tok_vld_in  (scale_done),
        .tok_thr_in  (threshold),
        .tok_id_in   ({ID_BITS{1'b0}}),
        .tok_vld_out (cell_tvld[i]),
        .tok_thr_out (cell_tthr[i]),
        .tok_id_out  (cell_tid[i])
      );
    end else begin : g_body
      wrc_cell #(
        .IDX      (i),
        .TOT_BITS (TOT_BITS),
        .ID_BITS  (ID_BITS),
        .CNT_BITS (CNT_BITS)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .shift_en    (is_add),
        .cum_in      (cell_cum[i-1]),
        .id_in       (cell_id[i-1]),
        .cum_out     (cell_cum[i]),
        .id_out      (cell_id[i]),
        .count       (count_r),
        .tok_vld_in  (cell_tvld[i-1]),
        .tok_thr_in  (cell_tthr[i-1]),
        .tok_id_in   (cell_tid[i-1]),
        .tok_vld_out (cell_tvld[i]),
        .tok_thr_out (cell_tthr[i]),
        .tok_id_out  (cell_tid[i])
      );
    end
  end

endmodule

[rtl/core/wrc_scaler.sv]
`timescale 1ns / 1ps

// Computes threshold = (draw * total) >> 32 with one 32x16 multiply per cycle.
// The total is consumed most significant slice first; each product is
// registered and folded into the accumulator on the following cycle.
module wrc_scaler #(
  parameter int unsigned TOT_BITS = 22
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [31:0]         draw,
  input  logic [TOT_BITS-1:0] total,
  output logic                done,
  output logic [TOT_BITS-1:0] threshold
);
  import wrc_pkg::*;

  localparam int unsigned NSLICE   = (TOT_BITS + SLICE_BITS - 1) / SLICE_BITS;
  localparam int unsigned PAD_BITS = NSLICE * SLICE_BITS;
  localparam int unsigned PROD_BITS = DRAW_BITS + SLICE_BITS;
  localparam int unsigned ACC_BITS = DRAW_BITS + PAD_BITS;
  localparam int unsigned STEP_BITS = $clog2(NSLICE + 1);

  logic                    busy_r;
  logic                    done_r;
  logic [STEP_BITS-1:0]    step_r;
  logic [DRAW_BITS-1:0]    draw_r;
  logic [PAD_BITS-1:0]     tot_sh_r;
  logic [PROD_BITS-1:0]    prod_r;
  logic [ACC_BITS-1:0]     acc_r;

  // Control: step counter runs one slice per cycle plus one final add.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && !start && (step_r == STEP_BITS'(NSLICE));
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        if (step_r == STEP_BITS'(NSLICE)) begin
          busy_r <= 1'b0;
        end
        step_r <= step_r + 1'b1;
      end
    end
  end

  // Datapath: multiply one slice, then shift and accumulate.
  always_ff @(posedge clk) begin
    if (start) begin
      draw_r   <= draw;
      tot_sh_r <= PAD_BITS'(total);
      acc_r    <= '0;
    end else if (busy_r) begin
      if (step_r < STEP_BITS'(NSLICE)) begin
        prod_r   <= draw_r * tot_sh_r[PAD_BITS-1 -: SLICE_BITS];
        tot_sh_r <= tot_sh_r << SLICE_BITS;
      end
      if (step_r != '0) begin
        acc_r <= (acc_r << SLICE_BITS) + ACC_BITS'(prod_r);
      end
    end
  end

  assign done      = done_r;
  assign threshold = acc_r[DRAW_BITS +: TOT_BITS];

endmodule

[rtl/core/wrc_cell.sv]
`timescale 1ns / 1ps

// One table entry. Entries shift one place down the row on every add, so the
// newest entry sits in the first cell. A search token passes one cell per
// cycle; each live cell whose cumulative weight exceeds the threshold
// replaces the carried id, so the deepest such cell (the oldest entry) wins.
module wrc_cell #(
  parameter int unsigned IDX       = 0,
  parameter int unsigned TOT_BITS  = 22,
  parameter int unsigned ID_BITS   = 16,
  parameter int unsigned CNT_BITS  = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift_en,
  input  logic [TOT_BITS-1:0] cum_in,
  input  logic [ID_BITS-1:0]  id_in,
  output logic [TOT_BITS-1:0] cum_out,
  output logic [ID_BITS-1:0]  id_out,
  input  logic [CNT_BITS-1:0] count,
  input  logic                tok_vld_in,
  input  logic [TOT_BITS-1:0] tok_thr_in,
  input  logic [ID_BITS-1:0]  tok_id_in,
  output logic                tok_vld_out,
  output logic [TOT_BITS-1:0] tok_thr_out,
  output logic [ID_BITS-1:0]  tok_id_out
);
  import wrc_pkg::*;

  logic [TOT_BITS-1:0] cum_r;
  logic [ID_BITS-1:0]  id_r;
  logic                tok_vld_r;
  logic [TOT_BITS-1:0] tok_thr_r;
  logic [ID_BITS-1:0]  tok_id_r;
  logic                hit;

  // Stored entry moves down the row on an add.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      cum_r <= cum_in;
      id_r  <= id_in;
    end
  end

  // The cell only counts when it holds one of the live entries.
  assign hit = (CNT_BITS'(IDX) < count) && (cum_r > tok_thr_in);

  // Search token stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_r <= 1'b0;
    end else begin
      tok_vld_r <= tok_vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_vld_in) begin
      tok_thr_r <= tok_thr_in;
      tok_id_r  <= hit ? id_r : tok_id_in;
    end
  end

  assign cum_out     = cum_r;
  assign id_out      = id_r;
  assign tok_vld_out = tok_vld_r;
  assign tok_thr_out = tok_thr_r;
  assign tok_id_out  = tok_id_r;

endmodule
